// File: rtl/core/http_chunked_deframer_assert.svh
// Assertion helpers for the deframer RTL, included by hcd_parser.
// The module that uses them must have clk and arst_n in scope.
`ifndef HTTP_CHUNKED_DEFRAMER_ASSERT_SVH
`define HTTP_CHUNKED_DEFRAMER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HCD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcd assertion failed");

// antecedent implies consequent in the next cycle
`define HCD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcd assertion failed");

`endif

// File: rtl/core/hcd_pkg.sv
`default_nettype none

package hcd_pkg;

	localparam int SIZE_BITS = 32;
	localparam int LINE_W    = 17;

	localparam logic [LINE_W-1:0] LINE_RESET = 17'h10000;
	localparam logic [LINE_W-1:0] COUNT_MAX  = '1;

	localparam logic [7:0] LF_CHAR = 8'h0A;
	localparam logic [7:0] CR_CHAR = 8'h0D;

	localparam logic [1:0] TERM_LEN = 2'd2;

	// byte_class codes
	localparam logic [1:0] CLS_SIZE    = 2'd0;
	localparam logic [1:0] CLS_PAYLOAD = 2'd1;
	localparam logic [1:0] CLS_TERM    = 2'd2;
	localparam logic [1:0] CLS_TRAILER = 2'd3;

	// error_code codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_LINE = 2'd1;
	localparam logic [1:0] ERR_OVFL = 2'd2;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  byte_class;
		logic        size_done;
		logic [31:0] chunk_size;
		logic        message_end;
		logic [1:0]  error_code;
	} hcd_result_t;

	// {is_hex, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (b inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/hcd_in_if.sv
`default_nettype none

interface hcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/hcd_out_if.sv
`default_nettype none

interface hcd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [1:0]  byte_class;
	logic        size_done;
	logic [31:0] chunk_size;
	logic        message_end;
	logic [1:0]  error_code;

	modport source (output valid, output out_byte, output byte_class, output size_done,
		output chunk_size, output message_end, output error_code, input ready);
	modport sink   (input valid, input out_byte, input byte_class, input size_done,
		input chunk_size, input message_end, input error_code, output ready);
endinterface

`default_nettype wire

// File: rtl/core/hcd_cfg_if.sv
`default_nettype none

interface hcd_cfg_if;
	logic        valid;
	logic        ready;
	logic [16:0] max_line_length;

	modport source (output valid, output max_line_length, input ready);
	modport sink   (input valid, input max_line_length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/hcd_parser.sv
`default_nettype none
`include "http_chunked_deframer_assert.svh"

module hcd_parser import hcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic [LINE_W-1:0] max_len,
	output hcd_result_t       res
);

	typedef enum logic [1:0] {
		PH_SIZE    = CLS_SIZE,
		PH_PAYLOAD = CLS_PAYLOAD,
		PH_TERM    = CLS_TERM,
		PH_TRAILER = CLS_TRAILER
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [SIZE_BITS-1:0] size_q, size_d;
	logic                 hex_stop_q, hex_stop_d;
	logic [SIZE_BITS-1:0] left_q, left_d;
	logic [1:0]           term_q, term_d;
	logic [LINE_W-1:0]    cnt_q, cnt_d;
	logic                 cr_q, cr_d;
	logic [1:0]           err_q, err_d;

	logic [4:0]           hex;
	logic [LINE_W-1:0]    cnt_inc;
	logic [SIZE_BITS-1:0] left_dec;
	logic [1:0]           term_dec;
	logic                 empty_line;

	always_comb begin
		hex        = hex_decode(data_byte);
		cnt_inc    = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
		left_dec   = (left_q != '0) ? left_q - 1'b1 : left_q;
		term_dec   = (term_q != '0) ? term_q - 1'b1 : term_q;
		empty_line = (cnt_q == '0) || (cnt_q == LINE_W'(1) && cr_q);

		phase_d    = phase_q;
		size_d     = size_q;
		hex_stop_d = hex_stop_q;
		left_d     = left_q;
		term_d     = term_q;
		cnt_d      = cnt_q;
		cr_d       = cr_q;
		err_d      = err_q;

		res.out_byte    = data_byte;
		res.byte_class  = phase_q;
		res.size_done   = 1'b0;
		res.chunk_size  = '0;
		res.message_end = 1'b0;

		if (err_q == ERR_NONE) begin
			case (phase_q)
				PH_PAYLOAD: begin
					left_d = left_dec;
					if (left_dec == '0) begin
						phase_d = PH_TERM;
						term_d  = TERM_LEN;
					end
				end
				PH_TERM: begin
					term_d = term_dec;
					if (term_dec == '0) begin
						phase_d    = PH_SIZE;
						size_d     = '0;
						hex_stop_d = 1'b0;
						cnt_d      = '0;
						cr_d       = 1'b0;
					end
				end
				default: begin
					if (data_byte == LF_CHAR) begin
						cnt_d = '0;
						cr_d  = 1'b0;
						if (phase_q == PH_SIZE) begin
							res.size_done  = 1'b1;
							res.chunk_size = 32'(size_q);
							if (size_q == '0) begin
								phase_d = PH_TRAILER;
							end else begin
								left_d  = size_q;
								phase_d = PH_PAYLOAD;
							end
						end else if (empty_line) begin
							// blank line closes the trailers, rearm for next message
							res.message_end = 1'b1;
							phase_d         = PH_SIZE;
							size_d          = '0;
							hex_stop_d      = 1'b0;
						end
					end else begin
						cnt_d = cnt_inc;
						cr_d  = (data_byte == CR_CHAR);
						if (cnt_inc > max_len) begin
							err_d = ERR_LINE;
						end else if (phase_q == PH_SIZE && !hex_stop_q) begin
							if (!hex[4]) begin
								hex_stop_d = 1'b1;
							end else if (size_q[SIZE_BITS-1 -: 4] != 4'h0) begin
								err_d = ERR_OVFL;
							end else begin
								size_d = {size_q[SIZE_BITS-5:0], hex[3:0]};
							end
						end
					end
				end
			endcase
		end

		res.error_code = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SIZE;
			size_q     <= '0;
			hex_stop_q <= 1'b0;
			left_q     <= '0;
			term_q     <= '0;
			cnt_q      <= '0;
			cr_q       <= 1'b0;
			err_q      <= ERR_NONE;
		end else if (step) begin
			phase_q    <= phase_d;
			size_q     <= size_d;
			hex_stop_q <= hex_stop_d;
			left_q     <= left_d;
			term_q     <= term_d;
			cnt_q      <= cnt_d;
			cr_q       <= cr_d;
			err_q      <= err_d;
		end
	end

	`HCD_ASSERT_NEXT(a_err_sticky, err_q != ERR_NONE, err_q == $past(err_q))
	`HCD_ASSERT_NOW(a_size_done_lf, res.size_done,
		phase_q == PH_SIZE && data_byte == LF_CHAR && err_q == ERR_NONE)
	`HCD_ASSERT_NOW(a_msg_end_trailer, res.message_end,
		phase_q == PH_TRAILER && !res.size_done)
	`HCD_ASSERT_NOW(a_chunk_only_on_done, res.chunk_size != '0, res.size_done)
	`HCD_ASSERT_NOW(a_payload_count_live, phase_q == PH_PAYLOAD, left_q != '0)

endmodule

`default_nettype wire

// File: rtl/core/http_chunked_deframer.sv
// channel   | dir | payload                                          | accepted when
// bytes     | in  | data_byte[7:0]                                   | valid & ready
// tags      | out | out_byte, byte_class, size_done, chunk_size,     | valid & ready
//           |     | message_end, error_code                          |
// cfg       | in  | max_line_length[16:0]                            | valid & ready
//
// One byte a cycle sustained while tags.ready holds; a taken byte is held in the input register,
// and its parser result is registered in the result register, which drives tags.
// Reset clears the parser state and the error, and sets max_line_length to 65536.
// A stalled result stays in the result register; the input register still takes
// one more request, and bytes.ready drops only when both are full.
`default_nettype none

module http_chunked_deframer import hcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	hcd_in_if.sink     bytes,
	hcd_out_if.source  tags,
	hcd_cfg_if.sink    cfg
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              valid_s2;
	hcd_result_t       res_s2;
	hcd_result_t       res;
	logic [LINE_W-1:0] max_len_q;
	logic              adv;

	assign adv         = valid_s1 && (!valid_s2 || tags.ready);
	assign bytes.ready = !valid_s1 || adv;
	assign cfg.ready   = 1'b1;

	hcd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.data_byte (byte_s1),
		.max_len   (max_len_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			max_len_q <= LINE_RESET;
		end else begin
			if (cfg.valid) begin
				max_len_q <= cfg.max_line_length;
			end
			if (bytes.ready) begin
				valid_s1 <= bytes.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (tags.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign tags.valid       = valid_s2;
	assign tags.out_byte    = res_s2.out_byte;
	assign tags.byte_class  = res_s2.byte_class;
	assign tags.size_done   = res_s2.size_done;
	assign tags.chunk_size  = res_s2.chunk_size;
	assign tags.message_end = res_s2.message_end;
	assign tags.error_code  = res_s2.error_code;

endmodule

`default_nettype wire

// File: tb/http_chunked_deframer_test.sv
`timescale 1ns / 1ps

module http_chunked_deframer_test import hcd_pkg::*; ();

	localparam int CYCLE_LIMIT = 100000;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_LEN    = 300;

	typedef enum int {END_LINE_LONG, END_OVERFLOW, END_BOTH, END_HUGE_SIZE} end_kind_e;

	logic clk;
	logic arst_n;

	hcd_in_if  byte_bus ();
	hcd_out_if res_bus ();
	hcd_cfg_if cfg_bus ();

	http_chunked_deframer u_top (clk, arst_n, byte_bus, res_bus, cfg_bus);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// parser state as the block should hold it
	logic [1:0]           ph           = CLS_SIZE;
	logic [SIZE_BITS-1:0] size_acc     = '0;
	logic                 hex_done     = 1'b0;
	logic [SIZE_BITS-1:0] payload_left = '0;
	logic [1:0]           term_left    = '0;
	logic [LINE_W-1:0]    line_len     = '0;
	logic                 prev_cr      = 1'b0;
	logic [1:0]           err          = ERR_NONE;
	logic [LINE_W-1:0]    line_limit   = LINE_RESET;

	logic [7:0]  byte_queue[$];
	hcd_result_t expected_tags[$];
	int          queued        = 0;
	int          sent_count    = 0;
	int          mismatches    = 0;
	int          cycles        = 0;
	int          hold_left     = 0;
	logic        hold_armed    = 1'b1;
	int          send_idle_pct = 15;
	int          recv_idle_pct = 46;

	function automatic logic decode_hex(input logic [7:0] b, output logic [3:0] nib);
		nib = b[3:0];
		if (b >= 8'h30 && b <= 8'h39) begin
			return 1'b1;
		end
		// letters: fold case, 'a' has low nibble 1
		nib = b[3:0] + 4'd9;
		return ((b | 8'h20) >= 8'h61) && ((b | 8'h20) <= 8'h66);
	endfunction

	function automatic void open_size_line();
		ph       = CLS_SIZE;
		size_acc = '0;
		hex_done = 1'b0;
		line_len = '0;
		prev_cr  = 1'b0;
	endfunction

	function automatic hcd_result_t parse_byte(input logic [7:0] b);
		hcd_result_t r;
		logic        hex;
		logic [3:0]  nib;
		r            = '0;
		r.out_byte   = b;
		r.byte_class = ph;
		hex          = decode_hex(b, nib);
		if (err == ERR_NONE) begin
			if (ph == CLS_PAYLOAD) begin
				if (payload_left != 0) payload_left = payload_left - 1'b1;
				if (payload_left == 0) begin
					ph        = CLS_TERM;
					term_left = TERM_LEN;
				end
			end else if (ph == CLS_TERM) begin
				if (term_left != 0) term_left = term_left - 1'b1;
				if (term_left == 0) open_size_line();
			end else if (b == LF_CHAR) begin
				if (ph == CLS_SIZE) begin
					r.size_done  = 1'b1;
					r.chunk_size = size_acc[31:0];
					if (size_acc == 0) begin
						ph       = CLS_TRAILER;
						line_len = '0;
						prev_cr  = 1'b0;
					end else begin
						payload_left = size_acc;
						ph           = CLS_PAYLOAD;
					end
				end else if (line_len == 0 || (line_len == 1 && prev_cr)) begin
					r.message_end = 1'b1;
					open_size_line();
				end else begin
					line_len = '0;
					prev_cr  = 1'b0;
				end
			end else begin
				if (line_len != COUNT_MAX) line_len = line_len + 1'b1;
				prev_cr = (b == CR_CHAR);
				if (line_len > line_limit) begin
					err = ERR_LINE;
				end else if (ph == CLS_SIZE && !hex_done) begin
					if (!hex) begin
						hex_done = 1'b1;
					end else if (size_acc[SIZE_BITS-1 -: 4] != 0) begin
						err = ERR_OVFL;
					end else begin
						size_acc = {size_acc[SIZE_BITS-5:0], nib};
					end
				end
			end
		end
		r.error_code = err;
		return r;
	endfunction

	// stream generation; lines are kept within the current limit so that no
	// error is raised before the closing section
	task automatic put_byte(input logic [7:0] b);
		byte_queue.insert(byte_queue.size(), b);
		queued++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] line_byte(input logic no_cr);
		logic [7:0] b;
		b = LF_CHAR;
		while (b == LF_CHAR || (no_cr && b == CR_CHAR)) b = any_byte();
		return b;
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		logic [3:0] nib;
		b = line_byte(1'b0);
		while (decode_hex(b, nib)) b = line_byte(1'b0);
		return b;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		if (d < 4'd10) return 8'h30 + 8'(d);
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(d - 4'd10);
	endfunction

	task automatic put_size_line(input logic [31:0] v, input int lim);
		logic [31:0] t;
		int          ndig;
		int          room;
		int          n;
		ndig = 0;
		for (t = v; t != 0; t = t >> 4) ndig++;
		if (v == 0 && lim > 0 && $urandom_range(0, 3) != 0) ndig = 1;
		room = lim - ndig;
		n    = (room > 0) ? $urandom_range(0, (room < 3) ? room : 3) : 0;
		repeat (n) put_byte(8'h30);
		room -= n;
		for (int i = ndig - 1; i >= 0; i--) put_byte(hex_char(v[4*i +: 4]));
		// chunk extension
		if (room >= 2 && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, (room - 1 < 6) ? room - 1 : 6);
			put_byte(8'h3B);
			repeat (n - 1) put_byte(line_byte(1'b0));
			room -= n;
		end
		if (room >= 1 && $urandom_range(0, 4) != 0) put_byte(CR_CHAR);
		put_byte(LF_CHAR);
	endtask

	task automatic put_trailers(input int lim);
		int len;
		if (lim > 0) begin
			repeat ($urandom_range(0, 2)) begin
				len = $urandom_range(1, (lim < 12) ? lim : 12);
				// a lone CR would read as the empty closing line
				if (len == 1) put_byte(line_byte(1'b1));
				else repeat (len) put_byte(line_byte(1'b0));
				put_byte(LF_CHAR);
			end
			if ($urandom_range(0, 1)) put_byte(CR_CHAR);
		end
		put_byte(LF_CHAR);
	endtask

	task automatic put_chunk(input int lim, input int max_size);
		int cap;
		int n;
		cap = max_size;
		if (lim == 1 && cap > 15) cap = 15;
		if (lim == 2 && cap > 255) cap = 255;
		n = $urandom_range(1, cap);
		put_size_line(n, lim);
		repeat (n) put_byte(any_byte());
		if ($urandom_range(0, 3) != 0) begin
			put_byte(CR_CHAR);
			put_byte(LF_CHAR);
		end else begin
			put_byte(any_byte());
			put_byte(any_byte());
		end
	endtask

	task automatic put_message(input int lim, input int max_size);
		int len;
		if (lim > 0) begin
			repeat ($urandom_range(0, 3)) begin
				put_chunk(lim, ($urandom_range(0, 19) == 0) ? 256 : max_size);
			end
			if ($urandom_range(0, 7) == 0) begin
				// junk size line: non-hex first, reads as size zero
				len = $urandom_range(1, (lim < 6) ? lim : 6);
				put_byte(plain_byte());
				repeat (len - 1) put_byte(line_byte(1'b0));
				put_byte(LF_CHAR);
			end else begin
				put_size_line(0, lim);
			end
		end else begin
			put_byte(LF_CHAR);
		end
		put_trailers(lim);
	endtask

	task automatic put_stream(input int lim, input int amount);
		int mark;
		mark = queued;
		while (queued < mark + amount) put_message(lim, 40);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (byte_queue.size() != 0 || byte_bus.valid || expected_tags.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_limit(input logic [LINE_W-1:0] v);
		@(posedge clk);
		cfg_bus.valid           <= 1'b1;
		cfg_bus.max_line_length <= v;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		line_limit     = v;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// byte sender
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_bus.valid <= 1'b0;
		end else begin
			if (byte_bus.valid && byte_bus.ready) begin
				expected_tags.insert(expected_tags.size(), parse_byte(byte_bus.data_byte));
				void'(byte_queue.pop_front());
				sent_count <= sent_count + 1;
			end
			if (!byte_bus.valid || byte_bus.ready) begin
				if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					byte_bus.valid     <= 1'b1;
					byte_bus.data_byte <= byte_queue[0];
				end else begin
					byte_bus.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so that the block backs up
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_armed && sent_count == HOLD_AT) begin
			hold_left  <= HOLD_LEN;
			hold_armed <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result receiver
	always @(posedge clk) begin : rx
		hcd_result_t want;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (expected_tags.size() == 0) begin
					$error("unexpected result, out_byte %0h", res_bus.out_byte);
					mismatches++;
				end else begin
					want = expected_tags.pop_front();
					check_field("out_byte", 32'(want.out_byte), 32'(res_bus.out_byte));
					check_field("byte_class", 32'(want.byte_class),
						32'(res_bus.byte_class));
					check_field("size_done", 32'(want.size_done), 32'(res_bus.size_done));
					check_field("chunk_size", want.chunk_size, res_bus.chunk_size);
					check_field("message_end", 32'(want.message_end),
						32'(res_bus.message_end));
					check_field("error_code", 32'(want.error_code),
						32'(res_bus.error_code));
				end
			end
			if (hold_left != 0) res_bus.ready <= 1'b0;
			else res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		end_kind_e ending;
		arst_n                  = 1'b0;
		byte_bus.valid          = 1'b0;
		byte_bus.data_byte      = '0;
		res_bus.ready           = 1'b0;
		cfg_bus.valid           = 1'b0;
		cfg_bus.max_line_length = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed, at the reset line limit
		put_text("1\r\n");
		put_byte(8'h00);
		put_text("\r\n");
		put_text("2\n");
		put_byte(8'hFF);
		put_byte(LF_CHAR);
		put_text("xy");
		put_text("0\r\nk\r\n\r\n");     // zero size, one trailer, CR-only end
		put_text("\n\n");               // empty size line, then empty trailer
		put_text(" 5\n\r\r\n\n");       // size with junk first byte
		wait_drained();

		write_limit(17'd1);
		put_stream(1, 80);
		wait_drained();

		// limit zero: only bare LF lines survive
		write_limit(17'd0);
		repeat (5) put_message(0, 1);
		wait_drained();

		send_idle_pct = 46;
		recv_idle_pct = 15;
		write_limit(COUNT_MAX);
		put_stream(int'(COUNT_MAX), 130);
		wait_drained();

		write_limit(17'd20);
		put_stream(20, 130);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_limit(LINE_RESET);
		put_stream(int'(LINE_RESET), 130);
		wait_drained();

		// closing section; errors stick until reset so only one is reachable
		ending = end_kind_e'($urandom_range(0, 3));
		case (ending)
			END_LINE_LONG: begin
				write_limit(17'd4);
				put_text("12345");
			end
			END_OVERFLOW: begin
				write_limit(LINE_RESET);
				put_text("FFFFFFFF7");
			end
			END_BOTH: begin
				write_limit(17'd8);
				put_text("100000000");
			end
			END_HUGE_SIZE: begin
				write_limit(LINE_RESET);
				put_text("fffffffF\r\n");
				repeat (300) put_byte(any_byte());
			end
		endcase
		repeat (30) put_byte(any_byte());
		wait_drained();
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/hcd_pkg.sv
rtl/core/hcd_in_if.sv
rtl/core/hcd_out_if.sv
rtl/core/hcd_cfg_if.sv
rtl/core/hcd_parser.sv
rtl/core/http_chunked_deframer.sv
tb/http_chunked_deframer_test.sv
